>>> design/assert_macros.svh
// Assertion macros shared by the checker files.
// Expects signals clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on clk, off while in reset.
`define LTS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("%m: check failed");

// Antecedent in one cycle, consequent in the next.
`define LTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("%m: check failed");

`endif

>>> design/lts_pkg.sv
// Shared types, constants and helpers of the Langevin trap stepper.
// No dependencies; the interfaces, the top level, the multiplier and the bench import it.
package lts_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int COUNT_BITS = 16;
	localparam int STEP_CNT_W = 16;
	localparam int LAST_W     = (COUNT_BITS > STEP_CNT_W) ? COUNT_BITS : STEP_CNT_W;

	typedef logic signed [31:0] fix_t;
	typedef logic        [30:0] ufix_t;
	typedef logic signed [32:0] mop_t;
	typedef logic signed [63:0] wide_t;

	localparam wide_t RND_HALF   = wide_t'(1) <<< (FRAC_BITS - 1);
	localparam wide_t RND_HALF_W = wide_t'(1) <<< FRAC_BITS;

	localparam ufix_t SPRING_K_RST    = 31'd65536;
	localparam ufix_t RELAX_RATE_RST  = 31'd65536;
	localparam fix_t  CENTER_RATE_RST = 32'sd0;
	localparam ufix_t TIME_STEP_RST   = 31'd6554;
	localparam ufix_t NOISE_SCALE_RST = 31'd29309;
	localparam logic [STEP_CNT_W-1:0] STEP_COUNT_RST = 16'd100;

	typedef enum logic [2:0] {
		CFG_SPRING_K    = 3'd0,
		CFG_RELAX_RATE  = 3'd1,
		CFG_CENTER_RATE = 3'd2,
		CFG_TIME_STEP   = 3'd3,
		CFG_NOISE_SCALE = 3'd4,
		CFG_STEP_COUNT  = 3'd5
	} cfg_reg_t;

	localparam int CFG_IDX_W = 3;

	// One request to the shared multiplier.
	typedef struct packed {
		mop_t a;
		mop_t b;
		logic extra_shift;
	} mul_req_t;

	function automatic fix_t sat32(input wide_t v);
		fix_t r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic mop_t s_op(input fix_t v);
		return mop_t'(v);
	endfunction

	function automatic mop_t u_op(input ufix_t v);
		return mop_t'({2'b00, v});
	endfunction

endpackage

>>> design/lts_if.sv
// Valid/ready channels of the Langevin trap stepper: step requests and results.
// Depends on lts_pkg.
interface lts_in_if;
	import lts_pkg::*;
	logic valid;
	logic ready;
	logic kind;
	fix_t start_offset;
	fix_t start_center;
	fix_t noise;

	modport source (output valid, output kind, output start_offset,
		output start_center, output noise, input ready);
	modport sink (input valid, input kind, input start_offset,
		input start_center, input noise, output ready);
endinterface

interface lts_out_if;
	import lts_pkg::*;
	logic valid;
	logic ready;
	fix_t position;
	fix_t work;
	logic last;

	modport source (output valid, output position, output work, output last,
		input ready);
	modport sink (input valid, input position, input work, input last,
		output ready);
endinterface

>>> design/langevin_trap_step.sv
// Langevin trap stepper top level: sequencer, state and configuration registers.
// Depends on lts_pkg, lts_if (lts_in_if, lts_out_if) and lts_mul.
//
// Steps one overdamped particle in a harmonic trap whose center moves at
// center_rate, Euler-Maruyama in signed Q16.16 with saturation, and keeps the
// work done on it. A start request (kind 0) loads position and center and
// clears work and step count. A step request (kind 1) runs seven products
// one after another through a single 33x33 multiplier, ordered by the
// chain through the new center, the drift and the work term. The block takes
// no request while one is in progress; a finished result waits in an output
// register, so the next request may be accepted before the result is taken.
// Every request gives one result.
module langevin_trap_step (
	input  logic                          clk,
	input  logic                          arst_n,
	lts_in_if.sink                        sample,
	lts_out_if.source                     result,
	input  logic                          cfg_we,
	input  logic [lts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_wdata
);
	import lts_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE = 12'h001,
		ST_C1   = 12'h002,
		ST_C2   = 12'h004,
		ST_C3   = 12'h008,
		ST_C4   = 12'h010,
		ST_C5   = 12'h020,
		ST_C6   = 12'h040,
		ST_C7   = 12'h080,
		ST_C8   = 12'h100,
		ST_C9   = 12'h200,
		ST_C10  = 12'h400,
		ST_DONE = 12'h800
	} state_t;

	state_t state_q;

	ufix_t spring_k_q;
	ufix_t relax_rate_q;
	fix_t  center_rate_q;
	ufix_t time_step_q;
	ufix_t noise_scale_q;
	logic [STEP_CNT_W-1:0] step_count_q;

	fix_t pos_q;
	fix_t center_q;
	fix_t work_q;
	logic [COUNT_BITS-1:0] steps_q;

	fix_t  noise_q;
	fix_t  newc_q;
	wide_t sq0_q;
	fix_t  n_q;
	fix_t  dsq_q;

	logic out_valid_q;
	fix_t out_pos_q;
	fix_t out_work_q;
	logic out_last_q;

	mul_req_t mreq;
	wide_t    rnd_wide;
	fix_t     rnd_sat;
	fix_t     d0;
	fix_t     d1;
	logic     in_acc;
	logic     out_load;

	lts_mul u_mul (
		.clk      (clk),
		.req      (mreq),
		.rnd_wide (rnd_wide),
		.rnd_sat  (rnd_sat)
	);

	assign sample.ready = (state_q == ST_IDLE);
	assign in_acc       = sample.valid && sample.ready;
	assign out_load     = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	assign d0 = sat32(wide_t'(pos_q) - wide_t'(center_q));
	assign d1 = sat32(wide_t'(pos_q) - wide_t'(newc_q));

	// Operand select for the shared multiplier.
	always_comb begin
		mreq = '0;
		case (state_q)
			ST_C1: begin
				mreq.a = s_op(center_rate_q);
				mreq.b = u_op(time_step_q);
			end
			ST_C2: begin
				mreq.a = s_op(d0);
				mreq.b = s_op(d0);
			end
			ST_C3: begin
				mreq.a = s_op(noise_q);
				mreq.b = u_op(noise_scale_q);
			end
			ST_C4: begin
				mreq.a = s_op(d1);
				mreq.b = s_op(d1);
			end
			ST_C5: begin
				mreq.a = u_op(relax_rate_q);
				mreq.b = s_op(d1);
			end
			ST_C7: begin
				mreq.a = s_op(rnd_sat);
				mreq.b = u_op(time_step_q);
			end
			ST_C8: begin
				mreq.a = u_op(spring_k_q);
				mreq.b = s_op(dsq_q);
				mreq.extra_shift = 1'b1;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spring_k_q    <= SPRING_K_RST;
			relax_rate_q  <= RELAX_RATE_RST;
			center_rate_q <= CENTER_RATE_RST;
			time_step_q   <= TIME_STEP_RST;
			noise_scale_q <= NOISE_SCALE_RST;
			step_count_q  <= STEP_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_SPRING_K:    spring_k_q    <= cfg_wdata[30:0];
				CFG_RELAX_RATE:  relax_rate_q  <= cfg_wdata[30:0];
				CFG_CENTER_RATE: center_rate_q <= cfg_wdata;
				CFG_TIME_STEP:   time_step_q   <= cfg_wdata[30:0];
				CFG_NOISE_SCALE: noise_scale_q <= cfg_wdata[30:0];
				CFG_STEP_COUNT:  step_count_q  <= cfg_wdata[STEP_CNT_W-1:0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	// Sequencer and particle state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			center_q    <= '0;
			work_q      <= '0;
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, or drop the one just taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!sample.kind) begin
							pos_q    <= sat32(wide_t'(sample.start_offset)
								+ wide_t'(sample.start_center));
							center_q <= sample.start_center;
							work_q   <= '0;
							steps_q  <= '0;
							state_q  <= ST_DONE;
						end else begin
							state_q <= ST_C1;
						end
					end
				end
				ST_C1: state_q <= ST_C2;
				ST_C2: state_q <= ST_C3;
				ST_C3: state_q <= ST_C4;
				ST_C4: state_q <= ST_C5;
				ST_C5: state_q <= ST_C6;
				ST_C6: state_q <= ST_C7;
				ST_C7: state_q <= ST_C8;
				ST_C8: state_q <= ST_C9;
				ST_C9: begin
					// drift from the multiplier, noise term held since C5
					pos_q    <= sat32(wide_t'(pos_q) - wide_t'(rnd_sat) + wide_t'(n_q));
					center_q <= newc_q;
					state_q  <= ST_C10;
				end
				ST_C10: begin
					work_q <= sat32(wide_t'(work_q) + wide_t'(rnd_sat));
					if (steps_q != {COUNT_BITS{1'b1}}) begin
						steps_q <= steps_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Intermediate terms and result payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			noise_q <= sample.noise;
		end
		if (state_q == ST_C3) begin
			newc_q <= sat32(wide_t'(center_q) + wide_t'(rnd_sat));
		end
		if (state_q == ST_C4) begin
			sq0_q <= rnd_wide;
		end
		if (state_q == ST_C5) begin
			n_q <= rnd_sat;
		end
		if (state_q == ST_C6) begin
			dsq_q <= sat32(rnd_wide - sq0_q);
		end
		if (out_load) begin
			out_pos_q  <= pos_q;
			out_work_q <= work_q;
			out_last_q <= (LAST_W'(steps_q) == LAST_W'(step_count_q));
		end
	end

	assign result.valid    = out_valid_q;
	assign result.position = out_pos_q;
	assign result.work     = out_work_q;
	assign result.last     = out_last_q;
endmodule

>>> design/lts_mul.sv
// Shared 33x33 signed multiplier with round-half-up and saturation, two stages.
// Depends on lts_pkg.
module lts_mul (
	input  logic              clk,
	input  lts_pkg::mul_req_t req,
	output lts_pkg::wide_t    rnd_wide,
	output lts_pkg::fix_t     rnd_sat
);
	import lts_pkg::*;

	logic signed [65:0] prod_full;
	wide_t prod_s1;
	logic  extra_s1;
	wide_t rnd;
	wide_t rnd_wide_s2;
	fix_t  rnd_sat_s2;

	assign prod_full = req.a * req.b;

	always_ff @(posedge clk) begin
		prod_s1  <= prod_full[63:0];
		extra_s1 <= req.extra_shift;
	end

	// Add half an output LSB, then floor by arithmetic shift.
	always_comb begin
		if (extra_s1) begin
			rnd = (prod_s1 + RND_HALF_W) >>> (FRAC_BITS + 1);
		end else begin
			rnd = (prod_s1 + RND_HALF) >>> FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		rnd_wide_s2 <= rnd;
		rnd_sat_s2  <= sat32(rnd);
	end

	assign rnd_wide = rnd_wide_s2;
	assign rnd_sat  = rnd_sat_s2;
endmodule

>>> design/lts_checker.sv
// Port-level checker of the Langevin trap stepper, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lts_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	logic       in_acc;
	logic       out_acc;
	logic [1:0] pending_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Requests accepted whose results are not yet taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	`LTS_ASSERT_NEXT(a_busy_after_req, in_acc, !in_ready)
	`LTS_ASSERT(a_result_has_req, !out_acc || (pending_q != 2'd0))
	`LTS_ASSERT(a_pending_bound, pending_q != 2'd3)
	`LTS_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid)
endmodule

bind langevin_trap_step lts_checker u_lts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready)
);

>>> dv/tb_langevin_trap_step.sv
// Self-checking bench for langevin_trap_step: start and step requests against a
// bit-exact Q16.16 particle integrator kept in the bench.
// Depends on lts_pkg, lts_in_if / lts_out_if and the langevin_trap_step top level.
module tb_langevin_trap_step;
	import lts_pkg::*;

	localparam int          RANDOM_ITEMS    = 1000;
	localparam int          FULL_RUN_STEPS  = 60;
	localparam int          HOLD_OFF_CYCLES = 300;
	localparam int          QUIET_LIMIT     = 4000;
	localparam int          SHOWN_FAULTS    = 10;
	localparam longint      Q_MAX           = 64'sd2147483647;
	localparam longint      Q_MIN           = -64'sd2147483648;
	localparam fix_t        FIX_MAX         = 32'sh7FFFFFFF;
	localparam fix_t        FIX_MIN         = 32'sh80000000;
	localparam fix_t        FIX_ONE         = 32'sh00010000;
	// indexes past the register list; writes there must change nothing
	localparam logic [2:0]  CFG_SPARE_6     = 3'd6;
	localparam logic [2:0]  CFG_SPARE_7     = 3'd7;

	typedef enum logic {REQ_START = 1'b0, REQ_STEP = 1'b1} req_kind_t;
	typedef enum bit {ROW_WRITE, ROW_SEND} row_op_t;

	typedef struct packed {
		fix_t position;
		fix_t work;
		logic last;
	} particle_report_t;

	typedef struct {
		row_op_t          op;
		logic [2:0]       idx;
		logic [31:0]      wdata;
		req_kind_t        kind;
		fix_t             offset;
		fix_t             center;
		fix_t             noise;
		bit               typed;
		particle_report_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;

	lts_in_if  sample_ch ();
	lts_out_if result_ch ();

	langevin_trap_step dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// register shadow
	ufix_t                 gain_k     = SPRING_K_RST;
	ufix_t                 gain_relax = RELAX_RATE_RST;
	fix_t                  drift_rate = CENTER_RATE_RST;
	ufix_t                 dt_q       = TIME_STEP_RST;
	ufix_t                 noise_gain = NOISE_SCALE_RST;
	logic [STEP_CNT_W-1:0] traj_len   = STEP_COUNT_RST;

	// particle state
	fix_t                  pos_st    = '0;
	fix_t                  center_st = '0;
	fix_t                  work_st   = '0;
	logic [COUNT_BITS-1:0] steps_st  = '0;

	particle_report_t due_reports[$];
	stim_row_t        directed_rows[$];

	bit calm          = 1'b0;
	bit choke_pending = 1'b0;
	int faults        = 0;
	int n_req         = 0;
	int n_start       = 0;
	int n_res         = 0;
	int n_last        = 0;
	int n_writes      = 0;
	int quiet_cycles  = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint clamp_q(input longint v);
		if (v > Q_MAX) return Q_MAX;
		if (v < Q_MIN) return Q_MIN;
		return v;
	endfunction

	// divide by 2^s, halves go toward plus infinity
	function automatic longint round_shr(input longint p, input int s);
		return (p + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return clamp_q(round_shr(a * b, FRAC_BITS));
	endfunction

	function automatic particle_report_t integrate_request(input req_kind_t kind,
			input fix_t off, input fix_t cen, input fix_t nz);
		longint x, oc, nc, d1, d0, dsq, term, t, drift, n;
		particle_report_t r;
		if (kind == REQ_START) begin
			pos_st    = fix_t'(clamp_q(longint'(off) + longint'(cen)));
			center_st = cen;
			work_st   = '0;
			steps_st  = '0;
		end else begin
			x     = longint'(pos_st);
			oc    = longint'(center_st);
			nc    = clamp_q(oc + qmul(longint'(drift_rate), longint'(dt_q)));
			d1    = clamp_q(x - nc);
			d0    = clamp_q(x - oc);
			dsq   = clamp_q(round_shr(d1 * d1, FRAC_BITS) - round_shr(d0 * d0, FRAC_BITS));
			term  = clamp_q(round_shr(longint'(gain_k) * dsq, FRAC_BITS + 1));
			work_st = fix_t'(clamp_q(longint'(work_st) + term));
			t     = qmul(longint'(gain_relax), d1);
			drift = qmul(t, longint'(dt_q));
			n     = qmul(longint'(nz), longint'(noise_gain));
			pos_st    = fix_t'(clamp_q(x - drift + n));
			center_st = fix_t'(nc);
			if (steps_st != '1) steps_st = steps_st + 1'b1;
		end
		r.position = pos_st;
		r.work     = work_st;
		r.last     = (steps_st == traj_len);
		return r;
	endfunction

	function automatic void log_fault(input string msg);
		faults++;
		if (faults <= SHOWN_FAULTS) $display("mismatch: %s", msg);
	endfunction

	// append one row to the directed table
	function automatic void add_row(input stim_row_t r);
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [31:0] data);
		stim_row_t r;
		r.op     = ROW_WRITE;
		r.idx    = idx;
		r.wdata  = data;
		r.kind   = REQ_STEP;
		r.offset = '0;
		r.center = '0;
		r.noise  = '0;
		r.typed  = 1'b0;
		r.want   = '0;
		return r;
	endfunction

	function automatic stim_row_t req_row(input req_kind_t kind, input fix_t off,
			input fix_t cen, input fix_t nz);
		stim_row_t r;
		r        = cfg_row('0, '0);
		r.op     = ROW_SEND;
		r.kind   = kind;
		r.offset = off;
		r.center = cen;
		r.noise  = nz;
		return r;
	endfunction

	function automatic stim_row_t known_row(input req_kind_t kind, input fix_t off,
			input fix_t cen, input fix_t nz, input fix_t pos, input fix_t wk, input logic lst);
		stim_row_t r;
		r       = req_row(kind, off, cen, nz);
		r.typed = 1'b1;
		r.want  = '{position: pos, work: wk, last: lst};
		return r;
	endfunction

	function automatic fix_t any_fix();
		fix_t v;
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(3))
					0: v = FIX_MAX;
					1: v = FIX_MIN;
					2: v = '0;
					default: v = '1;
				endcase
			end
			1: v = fix_t'($urandom);
			default: v = fix_t'(int'($urandom_range(0, 32'h80000)) - 32'sh40000);
		endcase
		return v;
	endfunction

	// mode 0 drives the top of the range, mode 1 zero, others mostly random up to typ
	function automatic logic [31:0] gain_word(input int mode, input int unsigned typ);
		logic [31:0] v;
		case (mode)
			0: v = 32'h7FFFFFFF;
			1: v = '0;
			default: begin
				case ($urandom_range(9))
					0: v = '0;
					1: v = 32'h7FFFFFFF;
					2: v = $urandom;
					default: v = $urandom_range(0, typ);
				endcase
			end
		endcase
		v[31] = $urandom_range(1);
		return v;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		sample_ch.valid <= 1'b0;
		while (due_reports.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_writes++;
		case (idx)
			CFG_SPRING_K:    gain_k     = data[30:0];
			CFG_RELAX_RATE:  gain_relax = data[30:0];
			CFG_CENTER_RATE: drift_rate = data;
			CFG_TIME_STEP:   dt_q       = data[30:0];
			CFG_NOISE_SCALE: noise_gain = data[30:0];
			CFG_STEP_COUNT:  traj_len   = data[STEP_CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_request(input req_kind_t kind, input fix_t off, input fix_t cen,
			input fix_t nz, input bit typed, input particle_report_t want);
		particle_report_t got;
		if (!calm && $urandom_range(3) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.kind         <= kind;
		sample_ch.start_offset <= off;
		sample_ch.start_center <= cen;
		sample_ch.noise        <= nz;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		got = integrate_request(kind, off, cen, nz);
		if (typed) got = want;
		due_reports.insert(due_reports.size(), got);
		n_req++;
		if (kind == REQ_START) n_start++;
	endtask

	task automatic send_start(input fix_t off, input fix_t cen);
		send_request(REQ_START, off, cen, fix_t'($urandom), 1'b0, '0);
	endtask

	task automatic send_step(input fix_t nz);
		send_request(REQ_STEP, fix_t'($urandom), fix_t'($urandom), nz, 1'b0, '0);
	endtask

	// result side: random back-pressure plus one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (choke_pending) begin
				choke_pending = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(4) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		particle_report_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			n_res++;
			if (result_ch.last) n_last++;
			if (due_reports.size() == 0) begin
				log_fault($sformatf("result with nothing pending: pos %h work %h last %b",
					result_ch.position, result_ch.work, result_ch.last));
			end else begin
				want = due_reports.pop_front();
				if (result_ch.position !== want.position)
					log_fault($sformatf("result %0d position expected %h got %h",
						n_res, want.position, result_ch.position));
				if (result_ch.work !== want.work)
					log_fault($sformatf("result %0d work expected %h got %h",
						n_res, want.work, result_ch.work));
				if (result_ch.last !== want.last)
					log_fault($sformatf("result %0d last expected %b got %b",
						n_res, want.last, result_ch.last));
			end
		end
	end

	// abort when no request, result or register write moves for too long
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
				|| cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", quiet_cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		int        setting;
		int        mode;
		int        n_steps;
		int        dir_items;
		logic [31:0] word;

		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= '0;
		cfg_wdata              <= '0;
		sample_ch.valid        <= 1'b0;
		sample_ch.kind         <= REQ_START;
		sample_ch.start_offset <= '0;
		sample_ch.start_center <= '0;
		sample_ch.noise        <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// step before any start, then position extremes, rate, spare indexes,
		// zero and short step counts, and saturating gains
		add_row(known_row(REQ_STEP, 32'sh5A5A5A5A, 32'shA5A5A5A5, '0,
			'0, '0, 1'b0));
		add_row(known_row(REQ_START, FIX_MAX, FIX_MAX, '1,
			FIX_MAX, '0, 1'b0));
		add_row(req_row(REQ_STEP, '0, '0, FIX_MIN));
		add_row(known_row(REQ_START, FIX_MIN, FIX_MIN, FIX_MAX,
			FIX_MIN, '0, 1'b0));
		add_row(req_row(REQ_STEP, '1, '1, FIX_MAX));
		add_row(known_row(REQ_START, FIX_MAX, FIX_MIN, '0,
			'1, '0, 1'b0));
		add_row(req_row(REQ_STEP, '0, '0, '1));
		add_row(cfg_row(CFG_CENTER_RATE, FIX_ONE));
		add_row(known_row(REQ_START, 5 * FIX_ONE, '0, FIX_MAX,
			5 * FIX_ONE, '0, 1'b0));
		add_row(req_row(REQ_STEP, '0, '0, '0));
		add_row(req_row(REQ_STEP, '0, '0, FIX_ONE));
		add_row(cfg_row(CFG_SPARE_6, 32'hFFFFFFFF));
		add_row(cfg_row(CFG_SPARE_7, 32'hFFFFFFFF));
		add_row(cfg_row(CFG_STEP_COUNT, '0));
		add_row(known_row(REQ_START, FIX_ONE, 2 * FIX_ONE, '0,
			3 * FIX_ONE, '0, 1'b1));
		add_row(req_row(REQ_STEP, '0, '0, '0));
		add_row(cfg_row(CFG_STEP_COUNT, 32'hFFFF0002));
		add_row(known_row(REQ_START, -3 * FIX_ONE, FIX_ONE, '0,
			-2 * FIX_ONE, '0, 1'b0));
		add_row(req_row(REQ_STEP, '0, '0, FIX_ONE));
		add_row(req_row(REQ_STEP, '0, '0, -FIX_ONE));
		add_row(req_row(REQ_STEP, '0, '0, '0));
		add_row(cfg_row(CFG_SPRING_K, 32'hFFFFFFFF));
		add_row(cfg_row(CFG_RELAX_RATE, 32'hFFFFFFFF));
		add_row(cfg_row(CFG_TIME_STEP, 32'hFFFFFFFF));
		add_row(cfg_row(CFG_NOISE_SCALE, 32'hFFFFFFFF));
		add_row(cfg_row(CFG_CENTER_RATE, FIX_MIN));
		add_row(req_row(REQ_STEP, '0, '0, FIX_MAX));
		add_row(req_row(REQ_STEP, '0, '0, FIX_MIN));
		add_row(known_row(REQ_START, FIX_MAX, '0, '0,
			FIX_MAX, '0, 1'b0));
		add_row(req_row(REQ_STEP, '0, '0, '0));
		add_row(req_row(REQ_STEP, '0, '0, FIX_ONE));

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.op == ROW_WRITE) begin
				write_reg(row.idx, row.wdata);
			end else begin
				send_request(row.kind, row.offset, row.center, row.noise, row.typed, row.want);
			end
		end
		dir_items = n_req;

		// random settings, each followed by a few trajectories with some noise
		setting = 0;
		while (n_req < dir_items + RANDOM_ITEMS) begin
			mode = (setting < 2) ? setting : $urandom_range(2, 9);
			write_reg(CFG_SPRING_K, gain_word(mode, 4 << FRAC_BITS));
			write_reg(CFG_RELAX_RATE, gain_word(mode, 4 << FRAC_BITS));
			write_reg(CFG_TIME_STEP, gain_word(mode, 1 << (FRAC_BITS - 1)));
			write_reg(CFG_NOISE_SCALE, gain_word(mode, 1 << FRAC_BITS));
			case (mode)
				0: word = FIX_MAX;
				1: word = FIX_MIN;
				default: word = ($urandom_range(3) == 0) ? any_fix() :
					fix_t'(int'($urandom_range(0, 32'h40000)) - 32'sh20000);
			endcase
			write_reg(CFG_CENTER_RATE, word);
			word = $urandom;
			case (mode)
				0: word[15:0] = 16'hFFFF;
				1: word[15:0] = '0;
				default: if ($urandom_range(7) != 0) word[15:0] = $urandom_range(0, 24);
			endcase
			write_reg(CFG_STEP_COUNT, word);
			if ($urandom_range(7) == 0)
				write_reg($urandom_range(1) ? CFG_SPARE_6 : CFG_SPARE_7, $urandom);
			calm = ($urandom_range(4) == 0);
			if (setting == 10) choke_pending = 1'b1;
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(9) != 0) send_start(any_fix(), any_fix());
				n_steps = (traj_len <= 30) ? int'(traj_len) : $urandom_range(1, 30);
				n_steps += $urandom_range(0, 3);
				if (setting == 10) n_steps = 12;
				else if ($urandom_range(5) == 0) n_steps = $urandom_range(0, n_steps);
				for (int s = 0; s < n_steps; s++) begin
					if ($urandom_range(19) == 0) send_start(any_fix(), any_fix());
					else send_step(any_fix());
				end
			end
			setting++;
		end

		// one trajectory that runs past its step count, no idling
		calm = 1'b1;
		write_reg(CFG_SPRING_K, FIX_ONE);
		write_reg(CFG_RELAX_RATE, FIX_ONE);
		write_reg(CFG_CENTER_RATE, 32'd1000);
		write_reg(CFG_TIME_STEP, 32'd6554);
		write_reg(CFG_NOISE_SCALE, 32'd29309);
		write_reg(CFG_STEP_COUNT, 32'd40);
		send_start('0, '0);
		for (int s = 0; s < FULL_RUN_STEPS; s++)
			send_step(fix_t'(int'($urandom_range(0, 32'h60000)) - 32'sh30000));
		sample_ch.valid <= 1'b0;

		while (due_reports.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("covered %0d requests (%0d starts), %0d results, %0d with last set",
			n_req, n_start, n_res, n_last);
		$display("%0d register writes over %0d random settings, %0d mismatches",
			n_writes, setting, faults);
		if (faults == 0 && due_reports.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> langevin_trap_step.f
+incdir+design
design/lts_pkg.sv
design/lts_if.sv
design/lts_mul.sv
design/langevin_trap_step.sv
design/lts_checker.sv
dv/tb_langevin_trap_step.sv
